// ===== hw/rtl/flock_separation_force_assert.svh =====
// assertion macros for the flock separation force block
// no dependencies
`ifndef FLOCK_SEPARATION_FORCE_ASSERT_SVH
`define FLOCK_SEPARATION_FORCE_ASSERT_SVH
`define FSF_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define FSF_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== hw/rtl/fsf_pkg.sv =====
// types and constants for the flock separation force block
// no dependencies
`default_nettype none
package fsf_pkg;
  localparam int PosW  = 24;
  localparam int SizeW = 23;
  localparam int ForceW = 32;
  localparam int WeightW = 16;
  localparam int DW = PosW + 1;
  localparam int DsqW = 2 * DW + 2;
  localparam int QDepth = 2;

  localparam logic ActLoad = 1'b0;
  localparam logic ActNbr  = 1'b1;

  typedef struct packed {
    logic action;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic [SizeW-1:0] radius_size;
    logic signed [ForceW-1:0] start_fx;
    logic signed [ForceW-1:0] start_fy;
    logic signed [ForceW-1:0] start_fz;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic signed [ForceW-1:0] force_x;
    logic signed [ForceW-1:0] force_y;
    logic signed [ForceW-1:0] force_z;
  } out_item_t;

  // classified work passed from front to back
  typedef struct packed {
    logic load;
    logic act;
    logic last;
    logic [DsqW-1:0] dsq;
    logic [2:0] neg;
    logic [DW-1:0] ax;
    logic [DW-1:0] ay;
    logic [DW-1:0] az;
    logic signed [ForceW-1:0] fx;
    logic signed [ForceW-1:0] fy;
    logic signed [ForceW-1:0] fz;
  } work_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SQRT, B_DIV, B_UPD, B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_SUM, F_CMP, F_PUSH
  } front_state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/flock_separation_force.sv =====
// flock separation force: accumulates a boids separation push for one particle
// load items skip the root and divide steps that neighbour items pass through
// back handles one neighbour at a time in the bit-serial root and divider, then takes the next
// front steps a neighbour through sq, sum, compare and push, a load straight to push; 2-entry queue between
// result is held in an output register until transferred
// reset (rst, synchronous) clears state and sets weight to 4096
`default_nettype none
module flock_separation_force import fsf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output out_item_t out_data,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [WeightW-1:0] weight;
  logic w_valid, w_full, q_pop, q_ne;
  work_t w_data, q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(weight) : '0;
  always_ff @(posedge clk) begin
    if (rst) weight <= WeightW'(4096);
    else if (psel && penable && pwrite && paddr == 2'd0) weight <= pwdata[WeightW-1:0];
  end

  fsf_front u_front (.clk, .rst, .in_valid, .in_stall, .in_data,
                     .w_valid, .w_full, .w_data);
  fsf_queue u_queue (.clk, .rst, .push(w_valid), .push_data(w_data), .full(w_full),
                     .pop(q_pop), .not_empty(q_ne), .pop_data(q_data));
  fsf_back u_back (.clk, .rst, .weight, .q_valid(q_ne), .q_data, .q_pop,
                   .out_valid, .out_stall, .out_data);

`include "flock_separation_force_assert.svh"
  `FSF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `FSF_ASSERT_IMP(a_pop_nonempty, q_pop, q_ne)
endmodule
`default_nettype wire

// ===== hw/rtl/fsf_front.sv =====
// front: accepts items, keeps own particle, computes distance and range test
// depends on fsf_pkg
`default_nettype none
module fsf_front import fsf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire in_item_t in_data,
  output logic w_valid,
  input  wire logic w_full,
  output work_t w_data
);
  front_state_t state, state_next;
  in_item_t item;
  logic signed [PosW-1:0] own_pos [3];
  logic [SizeW-1:0] own_size;
  logic [DW-1:0] a [3];
  logic [2:0] neg;
  logic [2*DW-1:0] sq [3];
  logic [DsqW-1:0] dsq;
  logic [SizeW+6:0] r51;
  logic [2*(SizeW+7)-1:0] rr;
  logic signed [DW-1:0] d [3];

  always_comb begin
    d[0] = DW'(item.pos_x) - DW'(own_pos[0]);
    d[1] = DW'(item.pos_y) - DW'(own_pos[1]);
    d[2] = DW'(item.pos_z) - DW'(own_pos[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      own_pos[0] <= '0; own_pos[1] <= '0; own_pos[2] <= '0;
      own_size <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && in_valid) begin
        item <= in_data;
        if (in_data.action == ActLoad) begin
          own_pos[0] <= in_data.pos_x;
          own_pos[1] <= in_data.pos_y;
          own_pos[2] <= in_data.pos_z;
          own_size <= in_data.radius_size;
        end
      end
      if (state == F_SQ) begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= d[i][DW-1];
          a[i] <= d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
        end
        r51 <= (SizeW+7)'(6'd51 * ((SizeW+7)'(own_size) + (SizeW+7)'(item.radius_size)));
      end
      if (state == F_SUM) begin
        for (int i = 0; i < 3; i++) sq[i] <= a[i] * a[i];
        rr <= r51 * r51;
      end
      if (state == F_CMP) begin
        dsq <= DsqW'(sq[0]) + DsqW'(sq[1]) + DsqW'(sq[2]);
      end
    end
  end

  // range test 10000*D < (51*S)^2
  logic [DsqW+13:0] dk;
  assign dk = (DsqW+14)'(dsq) * 14'd10000;

  always_comb begin
    state_next = state;
    in_stall = (state != F_IDLE);
    w_valid = 1'b0;
    unique case (state)
      F_IDLE: if (in_valid) state_next = (in_data.action == ActLoad) ? F_PUSH : F_SQ;
      F_SQ:   state_next = F_SUM;
      F_SUM:  state_next = F_CMP;
      F_CMP:  state_next = F_PUSH;
      F_PUSH: begin
        w_valid = 1'b1;
        if (!w_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
    w_data.load = (item.action == ActLoad);
    w_data.act = (item.action == ActNbr) && (dsq != '0) &&
                 ((DsqW+14)'(dk) < (DsqW+14)'(rr));
    w_data.last = item.last;
    w_data.dsq = dsq;
    w_data.neg = neg;
    w_data.ax = a[0];
    w_data.ay = a[1];
    w_data.az = a[2];
    w_data.fx = item.start_fx;
    w_data.fy = item.start_fy;
    w_data.fz = item.start_fz;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fsf_queue.sv =====
// short work queue between front and back
// depends on fsf_pkg
`default_nettype none
module fsf_queue import fsf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire work_t push_data,
  output logic full,
  input  wire logic pop,
  output logic not_empty,
  output work_t pop_data
);
  work_t mem [QDepth];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = (cnt == 2'(QDepth));
  assign not_empty = (cnt != '0);
  assign pop_data = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push && !full) begin
        mem[wp] <= push_data;
        wp <= ~wp;
      end
      if (pop && not_empty) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(pop && not_empty);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fsf_back.sv =====
// back: square root, per-axis division, force update and result register
// depends on fsf_pkg
`default_nettype none
module fsf_back import fsf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [WeightW-1:0] weight,
  input  wire logic q_valid,
  input  wire work_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);
  localparam int RootW = DsqW / 2;
  localparam int NumW = WeightW + DW;
  back_state_t state, state_next;
  work_t w;
  logic signed [ForceW-1:0] acc [3];
  logic [DsqW-1:0] rem_s;
  // holds the shifted partial root while iterating, final root fits RootW bits
  logic [DsqW-1:0] root;
  logic [DsqW-1:0] sbit;
  logic [NumW-1:0] num [3];
  logic [NumW-1:0] quo [3];
  logic [RootW:0] prem [3];
  logic [5:0] cnt;
  logic [DW-1:0] aa [3];

  always_comb begin
    aa[0] = w.ax; aa[1] = w.ay; aa[2] = w.az;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      acc[0] <= '0; acc[1] <= '0; acc[2] <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != B_OUT) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (q_valid) begin
          w <= q_data;
          rem_s <= q_data.dsq;
          root <= '0;
          sbit <= DsqW'(1) << (2*RootW - 2);
          cnt <= 6'(RootW);
        end
        B_SQRT: begin
          // one root bit per cycle
          if (rem_s >= root + sbit) begin
            rem_s <= rem_s - (root + sbit);
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            for (int i = 0; i < 3; i++) begin
              num[i] <= NumW'(weight) * NumW'(aa[i]);
              prem[i] <= '0;
            end
            cnt <= 6'(NumW);
          end
        end
        B_DIV: begin
          // restoring division, one quotient bit per cycle on all axes
          for (int i = 0; i < 3; i++) begin
            logic [RootW+1:0] t;
            t = {prem[i], num[i][NumW-1]};
            if (t >= (RootW+2)'(root)) begin
              prem[i] <= (RootW+1)'(t - (RootW+2)'(root));
              quo[i] <= {quo[i][NumW-2:0], 1'b1};
            end else begin
              prem[i] <= (RootW+1)'(t);
              quo[i] <= {quo[i][NumW-2:0], 1'b0};
            end
            num[i] <= num[i] << 1;
          end
          cnt <= cnt - 6'd1;
        end
        B_UPD: begin
          for (int i = 0; i < 3; i++) begin
            logic signed [ForceW+1:0] v;
            if (w.load) v = (ForceW+2)'(i == 0 ? w.fx : (i == 1 ? w.fy : w.fz));
            else if (w.act) begin
              if (w.neg[i]) v = (ForceW+2)'(acc[i]) + (ForceW+2)'(quo[i]);
              else v = (ForceW+2)'(acc[i]) - (ForceW+2)'(quo[i]);
            end else v = (ForceW+2)'(acc[i]);
            if (v > (ForceW+2)'(32'sh7fffffff)) acc[i] <= 32'sh7fffffff;
            else if (v < -(ForceW+2)'(33'sh080000000)) acc[i] <= 32'sh80000000;
            else acc[i] <= ForceW'(v);
          end
        end
        B_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_data.force_x <= acc[0];
          out_data.force_y <= acc[1];
          out_data.force_z <= acc[2];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      B_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = (!q_data.load && q_data.act) ? B_SQRT : B_UPD;
      end
      B_SQRT: if (cnt == 6'd1) state_next = B_DIV;
      B_DIV:  if (cnt == 6'd1) state_next = B_UPD;
      B_UPD:  state_next = w.last ? B_OUT : B_IDLE;
      B_OUT:  if (!out_valid || !out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end
endmodule
`default_nettype wire
